@@ sv/rv64_pkg.sv @@
// Shared types, opcodes and decode helpers for the RV64I execute unit.
`default_nettype none
package rv64_pkg;
    localparam int unsigned MemBytesDefault = 65536;

    localparam logic [6:0] OpLui    = 7'h37;
    localparam logic [6:0] OpAuipc  = 7'h17;
    localparam logic [6:0] OpJal    = 7'h6f;
    localparam logic [6:0] OpJalr   = 7'h67;
    localparam logic [6:0] OpBranch = 7'h63;
    localparam logic [6:0] OpLoad   = 7'h03;
    localparam logic [6:0] OpStore  = 7'h23;
    localparam logic [6:0] OpImm    = 7'h13;
    localparam logic [6:0] OpImm32  = 7'h1b;
    localparam logic [6:0] OpReg    = 7'h33;
    localparam logic [6:0] OpFence  = 7'h0f;
    localparam logic [6:0] OpSystem = 7'h73;

    localparam logic [31:0] InstrEcall  = 32'h0000_0073;
    localparam logic [31:0] InstrEbreak = 32'h0010_0073;
    localparam logic [6:0]  F7Alt       = 7'h20;
    localparam logic [5:0]  Hi6Sra      = 6'h10;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic [31:0] instr;
        logic        bad;
    } t_req;
endpackage
`default_nettype wire

@@ sv/rv64_front.sv @@
// Front end: accepts instruction requests, flags illegal encodings, queues them.
`default_nettype none
module rv64_front
    import rv64_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instr,
    output logic             o_q_valid,
    output t_req             o_q_req,
    input  wire logic        i_q_pop
);
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       bad;
    t_req       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push;

    assign op = i_instr[6:0];
    assign f3 = i_instr[14:12];
    assign f7 = i_instr[31:25];

    always_comb begin
        bad = 1'b0;
        unique case (op)
            OpLui, OpAuipc, OpJal: bad = 1'b0;
            OpJalr:   bad = (f3 != 3'd0);
            OpBranch: bad = (f3 == 3'd2) || (f3 == 3'd3);
            OpLoad:   bad = (f3 == 3'd7);
            OpStore:  bad = f3[2];
            OpImm: begin
                if (f3 == 3'd1)
                    bad = (i_instr[31:26] != 6'd0);
                else if (f3 == 3'd5)
                    bad = (i_instr[31:26] != 6'd0) && (i_instr[31:26] != Hi6Sra);
            end
            OpImm32: begin
                if (f3 == 3'd0) bad = 1'b0;
                else if (f3 == 3'd1) bad = (f7 != 7'd0);
                else if (f3 == 3'd5) bad = (f7 != 7'd0) && (f7 != F7Alt);
                else bad = 1'b1;
            end
            OpReg: bad = !((f7 == 7'd0) ||
                           ((f7 == F7Alt) && ((f3 == 3'd0) || (f3 == 3'd5))));
            OpFence:  bad = (f3 > 3'd1);
            OpSystem: bad = (i_instr != InstrEcall) && (i_instr != InstrEbreak);
            default:  bad = 1'b1;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= '{instr: i_instr, bad: bad};
        if (!i_rst_n) begin
            r_wr <= 1'b0; r_rd <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("queue popped while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("full queue not stalling");
`endif
endmodule
`default_nettype wire

@@ sv/rv64_back.sv @@
// Back end: register file, data memory and execution sequencer.
`default_nettype none
module rv64_back
    import rv64_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_q_valid,
    input  t_req             i_q_req,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_next_pc,
    output logic             o_reg_written,
    output logic [4:0]       o_dest_index,
    output logic [63:0]      o_dest_value,
    output logic             o_store_done,
    output logic             o_unrecognised
);
    // Data memory is split into eight byte banks by offset bits [2:0]; one row per bank
    // is touched per cycle, so any access of up to eight bytes hits each bank once.
    localparam int unsigned BankDepth = (MEM_BYTES + 7) / 8;
    localparam int unsigned RW = (BankDepth > 1) ? $clog2(BankDepth) : 1;
    localparam logic [63:0] MemSize = 64'(MEM_BYTES);
    localparam logic [1:0] S_IDLE = 2'd0, S_MEM = 2'd1, S_CLR = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [63:0] r_regs [31];
    logic [63:0] r_pc, r_base;
    logic [RW-1:0] r_clr;
    logic [7:0]  r_rmap;
    logic [2:0]  r_lo;
    t_req        r_cur;

    logic [31:0] w;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] a, b, immi, imms, immb, immu, immj, res, npc, ad, off0;
    logic        wr, st, tk, lts, ltu, ltsi, ltui;
    logic [5:0]  sh;
    logic [31:0] r32;
    logic [63:0] ld, ldx;
    logic        fire, out_free;
    logic [63:0] b_off [8];
    logic        b_in [8];
    logic [2:0]  st_n;
    logic [2:0]  bk_k [8];
    logic [RW-1:0] bk_row [8];
    logic        bk_we [8];
    logic [7:0]  bk_wdat [8];
    logic [7:0]  bank_q [8];

    assign out_free = !o_valid || !i_stall;
    assign w   = (r_state == S_MEM) ? r_cur.instr : i_q_req.instr;
    assign op  = w[6:0];
    assign rd  = w[11:7];
    assign f3  = w[14:12];
    assign rs1 = w[19:15];
    assign rs2 = w[24:20];
    assign a   = (rs1 == 5'd0) ? 64'd0 : r_regs[rs1 - 5'd1];
    assign b   = (rs2 == 5'd0) ? 64'd0 : r_regs[rs2 - 5'd1];
    assign immi = {{52{w[31]}}, w[31:20]};
    assign imms = {{52{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immu = {{32{w[31]}}, w[31:12], 12'd0};
    assign immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign ad   = a + ((op == OpStore) ? imms : immi);
    assign off0 = ad - r_base;
    assign lts  = $signed(a) < $signed(b);
    assign ltu  = a < b;
    assign ltsi = $signed(a) < $signed(immi);
    assign ltui = a < immi;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            b_off[k] = off0 + 64'(k);
            b_in[k]  = b_off[k] < MemSize;
        end
    end

    // Byte k of the access lives in bank (off0 + k) mod 8.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            bk_k[j]    = 3'(j) - off0[2:0];
            bk_row[j]  = b_off[bk_k[j]][RW+2:3];
            bk_we[j]   = fire && st && (bk_k[j] <= st_n) && b_in[bk_k[j]];
            bk_wdat[j] = b[8*bk_k[j] +: 8];
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_bank
        logic [7:0] r_bank [BankDepth];
        logic [7:0] r_bdat;
        always_ff @(posedge i_clk) begin
            if (r_state == S_CLR)
                r_bank[r_clr] <= 8'd0;
            else if (bk_we[j])
                r_bank[bk_row[j]] <= bk_wdat[j];
            r_bdat <= r_bank[bk_row[j]];
        end
        assign bank_q[j] = r_bdat;
    end

    // Load assembly from registered byte reads.
    always_comb begin
        ld = '0;
        for (int k = 0; k < 8; k++)
            ld[8*k +: 8] = r_rmap[k] ? bank_q[r_lo + 3'(k)] : 8'd0;
        case (f3)
            3'd0:    ldx = {{56{ld[7]}}, ld[7:0]};
            3'd1:    ldx = {{48{ld[15]}}, ld[15:0]};
            3'd2:    ldx = {{32{ld[31]}}, ld[31:0]};
            3'd4:    ldx = {56'd0, ld[7:0]};
            3'd5:    ldx = {48'd0, ld[15:0]};
            3'd6:    ldx = {32'd0, ld[31:0]};
            default: ldx = ld;
        endcase
    end

    always_comb begin
        res = '0; wr = 1'b0; st = 1'b0; tk = 1'b0; r32 = '0;
        npc = r_pc + 64'd4;
        sh = 6'd0;
        if (!((r_state == S_MEM) ? r_cur.bad : i_q_req.bad)) begin
            case (op)
                OpLui:   begin res = immu; wr = 1'b1; end
                OpAuipc: begin res = r_pc + immu; wr = 1'b1; end
                OpJal:   begin res = r_pc + 64'd4; wr = 1'b1; npc = r_pc + immj; end
                OpJalr:  begin
                    res = r_pc + 64'd4; wr = 1'b1;
                    npc = (a + immi) & ~64'd1;
                end
                OpBranch: begin
                    case (f3)
                        3'd0: tk = (a == b);
                        3'd1: tk = (a != b);
                        3'd4: tk = lts;
                        3'd5: tk = !lts;
                        3'd6: tk = ltu;
                        default: tk = !ltu;
                    endcase
                    if (tk) npc = r_pc + immb;
                end
                OpLoad:  begin res = ldx; wr = 1'b1; end
                OpStore: st = 1'b1;
                OpImm: begin
                    wr = 1'b1; sh = immi[5:0];
                    case (f3)
                        3'd0: res = a + immi;
                        3'd1: res = a << sh;
                        3'd2: res = {63'd0, ltsi};
                        3'd3: res = {63'd0, ltui};
                        3'd4: res = a ^ immi;
                        3'd5: res = w[30] ? 64'($signed(a) >>> sh) : a >> sh;
                        3'd6: res = a | immi;
                        default: res = a & immi;
                    endcase
                end
                OpImm32: begin
                    wr = 1'b1;
                    case (f3)
                        3'd0: r32 = a[31:0] + immi[31:0];
                        3'd1: r32 = a[31:0] << w[24:20];
                        default: r32 = w[30] ? 32'($signed(a[31:0]) >>> w[24:20])
                                             : a[31:0] >> w[24:20];
                    endcase
                    res = {{32{r32[31]}}, r32};
                end
                OpReg: begin
                    wr = 1'b1; sh = b[5:0];
                    case (f3)
                        3'd0: res = w[30] ? a - b : a + b;
                        3'd1: res = a << sh;
                        3'd2: res = {63'd0, lts};
                        3'd3: res = {63'd0, ltu};
                        3'd4: res = a ^ b;
                        3'd5: res = w[30] ? 64'($signed(a) >>> sh) : a >> sh;
                        3'd6: res = a | b;
                        default: res = a & b;
                    endcase
                end
                default: ;
            endcase
        end
        if (rd == 5'd0) wr = 1'b0;
    end

    // Loads wait in S_MEM for the registered memory read.
    logic is_load, start;
    assign is_load = (i_q_req.instr[6:0] == OpLoad) && !i_q_req.bad;
    assign start   = (r_state == S_IDLE) && i_q_valid && out_free;
    assign fire    = (start && !is_load) || ((r_state == S_MEM) && out_free);
    assign o_q_pop = start;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == RW'(BankDepth - 1)) n_state = S_IDLE;
            S_IDLE: if (start && is_load) n_state = S_MEM;
            S_MEM:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign st_n = (3'd1 << f3[1:0]) - 3'd1;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur <= i_q_req;
            r_lo  <= off0[2:0];
            for (int k = 0; k < 8; k++) r_rmap[k] <= b_in[k];
        end
        if (fire) begin
            o_next_pc      <= npc;
            o_reg_written  <= wr;
            o_dest_index   <= wr ? rd : 5'd0;
            o_dest_value   <= wr ? res : 64'd0;
            o_store_done   <= st;
            o_unrecognised <= (r_state == S_MEM) ? r_cur.bad : i_q_req.bad;
        end
        if (fire && wr) r_regs[rd - 5'd1] <= res;
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_pc <= '0; r_base <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < 31; k++) r_regs[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + RW'(1);
            if (i_cfg_we) r_base <= i_cfg_data;
            if (fire) r_pc <= npc;
            if (fire) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_next_pc)) else $error("result changed under stall");
    a_no_fire_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop) else $error("request taken during clear");
    a_wr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reg_written) |-> (o_dest_index != 5'd0))
        else $error("write to x0 reported");
`endif
endmodule
`default_nettype wire

@@ sv/rv64i_execute_unit.sv @@
// Top level of the RV64I execute unit: front end, request queue and back end.
// Usage:
//  - Input channel i_valid/o_stall carries one 32-bit instruction per request,
//    executed at the internal pc (starts at 0 after reset).
//  - Output channel o_valid/i_stall returns next pc, register write, store and
//    unrecognised flags, one result per request, in order.
//  - i_cfg_we/i_cfg_data set the data memory base; write only while idle.
//  - Non-loads pass through the queue and execute into the output register;
//    loads also wait on the registered data memory read port.
//  - One non-load request per cycle while the receiver does not stall; a load holds
//    the back end's single execute sequencer until its memory read is done.
//  - Reset (synchronous, active low) clears registers and pc, then runs a
//    clearing pass over the MEM_BYTES/8 rows (8192 at the default size) of the
//    eight data memory byte banks; o_stall holds high once the two-entry
//    queue fills during that time.
//  - When the receiver stalls, the result register holds its value and the
//    two-entry queue soaks up to two more requests before o_stall rises.
`default_nettype none
module rv64i_execute_unit
    import rv64_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instr,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_next_pc,
    output logic             o_reg_written,
    output logic [4:0]       o_dest_index,
    output logic [63:0]      o_dest_value,
    output logic             o_store_done,
    output logic             o_unrecognised
);
    logic q_valid, q_pop;
    t_req q_req;

    rv64_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_instr,
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    rv64_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_next_pc, .o_reg_written, .o_dest_index,
        .o_dest_value, .o_store_done, .o_unrecognised
    );
endmodule
`default_nettype wire

@@ verif/rv64i_execute_unit_test.sv @@
// Self-checking testbench for the RV64I execute unit, with directed and random instructions.
`default_nettype none
module rv64i_execute_unit_test;
    import rv64_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MemSize   = MemBytesDefault;
    localparam int unsigned Settle    = 8;     // cycles to let the pipeline drain
    localparam int unsigned RandItems = 325;   // random requests per memory base
    localparam int unsigned LongHold  = 400;   // receiver hold-off, cycles

    // Result of one instruction, as the block reports it.
    typedef struct packed {
        logic [63:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic        store_done;
        logic        unrecognised;
    } exec_result_t;

    // Directed row: instruction, and optionally a result known by inspection.
    typedef struct {
        logic [31:0]  instr;
        bit           known;
        exec_result_t want;
    } directed_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_instr = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_next_pc;
    logic        o_reg_written;
    logic [4:0]  o_dest_index;
    logic [63:0] o_dest_value;
    logic        o_store_done;
    logic        o_unrecognised;

    rv64i_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_instr(i_instr),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_next_pc(o_next_pc), .o_reg_written(o_reg_written),
        .o_dest_index(o_dest_index), .o_dest_value(o_dest_value),
        .o_store_done(o_store_done), .o_unrecognised(o_unrecognised)
    );

    always #10ns i_clk = ~i_clk;

    // Architectural state mirrored by the predictor.
    logic [63:0] arch_regs [32];
    logic [63:0] arch_pc;
    logic [7:0]  arch_mem [MemSize];
    logic [63:0] arch_base;

    exec_result_t pending_results [$];
    int unsigned  mismatches;
    bit           hold_request;   // asks the receiver for one long hold-off
    int unsigned  burst_left;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] mem_read_byte(input logic [63:0] addr);
        logic [63:0] off;
        off = addr - arch_base;
        return (off < MemSize) ? arch_mem[off] : 8'h00;
    endfunction

    function automatic logic [63:0] load_le(input logic [63:0] addr, input int unsigned n);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < n; k++) v[8*k +: 8] = mem_read_byte(addr + k);
        return v;
    endfunction

    task automatic store_le(input logic [63:0] addr, input logic [63:0] v, input int unsigned n);
        logic [63:0] off;
        for (int k = 0; k < n; k++) begin
            off = addr + k - arch_base;
            if (off < MemSize) arch_mem[off] = v[8*k +: 8];
        end
    endtask

    // Executes one instruction on the mirrored state and returns its result.
    task automatic execute_instr(input logic [31:0] w, output exec_result_t r);
        logic [6:0]  op, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [5:0]  hi6, sh;
        logic [63:0] immi, imms, immb, immu, immj, a, b, pc, npc, res, ad;
        logic [31:0] x, r32;
        bit          wr, st, bad, taken;
        op  = w[6:0];   rd = w[11:7]; f3 = w[14:12];
        rs1 = w[19:15]; rs2 = w[24:20]; f7 = w[31:25]; hi6 = w[31:26];
        immi = {{52{w[31]}}, w[31:20]};
        imms = {{52{w[31]}}, w[31:25], w[11:7]};
        immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        immu = {{32{w[31]}}, w[31:12], 12'h000};
        immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        a = arch_regs[rs1]; b = arch_regs[rs2];
        pc = arch_pc; npc = pc + 4; res = '0;
        wr = 0; st = 0; bad = 0; taken = 0;
        case (op)
            OpLui: begin res = immu; wr = 1; end
            OpAuipc: begin res = pc + immu; wr = 1; end
            OpJal: begin res = pc + 4; wr = 1; npc = pc + immj; end
            OpJalr: begin
                if (f3 != 0) bad = 1;
                else begin
                    res = pc + 4; wr = 1;
                    npc = (a + immi) & ~64'd1;
                end
            end
            OpBranch: begin
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = ($signed(a) < $signed(b));
                    3'd5: taken = !($signed(a) < $signed(b));
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: bad = 1;
                endcase
                if (taken) npc = pc + immb;
            end
            OpLoad: begin
                ad = a + immi;
                case (f3)
                    3'd0: begin res = load_le(ad, 1); res = {{56{res[7]}}, res[7:0]}; end
                    3'd1: begin res = load_le(ad, 2); res = {{48{res[15]}}, res[15:0]}; end
                    3'd2: begin res = load_le(ad, 4); res = {{32{res[31]}}, res[31:0]}; end
                    3'd3: res = load_le(ad, 8);
                    3'd4: res = load_le(ad, 1);
                    3'd5: res = load_le(ad, 2);
                    3'd6: res = load_le(ad, 4);
                    default: bad = 1;
                endcase
                wr = !bad;
            end
            OpStore: begin
                if (f3 > 3) bad = 1;
                else begin
                    store_le(a + imms, b, 1 << f3);
                    st = 1;
                end
            end
            OpImm: begin
                sh = immi[5:0];
                case (f3)
                    3'd0: res = a + immi;
                    3'd1: if (hi6 != 0) bad = 1; else res = a << sh;
                    3'd2: res = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
                    3'd3: res = (a < immi) ? 64'd1 : 64'd0;
                    3'd4: res = a ^ immi;
                    3'd5: begin
                        if (hi6 == 0) res = a >> sh;
                        else if (hi6 == Hi6Sra) res = $signed(a) >>> sh;
                        else bad = 1;
                    end
                    3'd6: res = a | immi;
                    default: res = a & immi;
                endcase
                wr = !bad;
            end
            OpImm32: begin
                x = a[31:0]; r32 = '0;
                sh = {1'b0, immi[4:0]};
                if (f3 == 0) r32 = x + immi[31:0];
                else if (f3 == 1 && f7 == 0) r32 = x << sh;
                else if (f3 == 5 && f7 == 0) r32 = x >> sh;
                else if (f3 == 5 && f7 == F7Alt) r32 = $signed(x) >>> sh;
                else bad = 1;
                res = {{32{r32[31]}}, r32};
                wr = !bad;
            end
            OpReg: begin
                sh = b[5:0];
                if (f7 == 0) begin
                    case (f3)
                        3'd0: res = a + b;
                        3'd1: res = a << sh;
                        3'd2: res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        3'd3: res = (a < b) ? 64'd1 : 64'd0;
                        3'd4: res = a ^ b;
                        3'd5: res = a >> sh;
                        3'd6: res = a | b;
                        default: res = a & b;
                    endcase
                end else if (f7 == F7Alt && f3 == 0) res = a - b;
                else if (f7 == F7Alt && f3 == 5) res = $signed(a) >>> sh;
                else bad = 1;
                wr = !bad;
            end
            OpFence: if (f3 > 1) bad = 1;
            OpSystem: if (w != InstrEcall && w != InstrEbreak) bad = 1;
            default: bad = 1;
        endcase
        if (bad) begin
            wr = 0; st = 0; npc = pc + 4;
        end
        if (rd == 0) wr = 0;
        if (wr) arch_regs[rd] = res;
        arch_pc = npc;
        r.next_pc      = npc;
        r.reg_written  = wr;
        r.dest_index   = wr ? rd : 5'd0;
        r.dest_value   = wr ? res : 64'd0;
        r.store_done   = st;
        r.unrecognised = bad;
    endtask

    // Random instruction, mostly well-formed, spread over every opcode class.
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        int unsigned pick;
        w    = $urandom();
        rd   = 5'($urandom_range(0, 31));
        rs1  = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        rs2  = 5'($urandom_range(0, 31));
        f3   = 3'($urandom_range(0, 7));
        f7   = ($urandom_range(0, 7) == 0) ? 7'($urandom()) :
               ($urandom_range(0, 1) == 0) ? 7'h00 : F7Alt;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return {w[31:12], rd, ($urandom_range(0, 1) == 0) ? OpLui : OpAuipc};
        if (pick < 16)
            return {w[31:20], rs1, 3'd0, rd, OpImm};
        if (pick < 30) begin
            // shift immediates: legal, arithmetic or junk upper bits
            if (f3 == 1 || f3 == 5)
                w[31:26] = ($urandom_range(0, 5) == 0) ? w[31:26] :
                           ($urandom_range(0, 1) == 0) ? 6'h00 : Hi6Sra;
            return {w[31:20], rs1, f3, rd, OpImm};
        end
        if (pick < 38)
            return {f7, w[24:20], rs1, f3, rd, OpImm32};
        if (pick < 50)
            return {f7, rs2, rs1, f3, rd, OpReg};
        if (pick < 62)
            return {w[31:20], rs1, f3, rd, OpLoad};
        if (pick < 74) begin
            if ($urandom_range(0, 5) != 0) f3[2] = 1'b0;
            return {w[31:25], rs2, rs1, f3, w[11:7], OpStore};
        end
        if (pick < 84) begin
            // keep most branch targets close by
            if ($urandom_range(0, 3) != 0) w[31:25] = {7{w[31]}};
            return {w[31:25], rs2, rs1, f3, w[11:7], OpBranch};
        end
        if (pick < 88) begin
            if ($urandom_range(0, 1) == 0) return {w[31:12], rd, OpJal};
            return {w[31:20], rs1, ($urandom_range(0, 7) == 0) ? f3 : 3'd0, rd, OpJalr};
        end
        if (pick < 92) begin
            case ($urandom_range(0, 3))
                0: return InstrEcall;
                1: return InstrEbreak;
                2: return {w[31:15], f3, w[11:7], OpFence};
                default: return {w[31:7], OpSystem};
            endcase
        end
        return w;
    endfunction

    // Offers one request, predicts it once accepted, then maybe idles.
    task automatic send_request(input logic [31:0] w, output exec_result_t r);
        i_valid <= 1'b1;
        i_instr <= w;
        do @(posedge i_clk); while (o_stall);
        execute_instr(w, r);
        pending_results.push_back(r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                i_instr <= $urandom();
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Waits for the block to drain, then writes the memory base.
    task automatic set_mem_base(input logic [63:0] base);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        arch_base = base;
    endtask

    function automatic exec_result_t known_result(input logic [63:0] npc, input bit wr,
            input logic [4:0] rd, input logic [63:0] val, input bit st, input bit bad);
        exec_result_t r;
        r.next_pc = npc; r.reg_written = wr; r.dest_index = rd;
        r.dest_value = val; r.store_done = st; r.unrecognised = bad;
        return r;
    endfunction

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        exec_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("MISMATCH at %0t: result with none expected", $realtime);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_next_pc !== want.next_pc) report("next_pc", o_next_pc, want.next_pc);
                if (o_reg_written !== want.reg_written)
                    report("reg_written", o_reg_written, want.reg_written);
                if (o_dest_index !== want.dest_index)
                    report("dest_index", o_dest_index, want.dest_index);
                if (o_dest_value !== want.dest_value)
                    report("dest_value", o_dest_value, want.dest_value);
                if (o_store_done !== want.store_done)
                    report("store_done", o_store_done, want.store_done);
                if (o_unrecognised !== want.unrecognised)
                    report("unrecognised", o_unrecognised, want.unrecognised);
            end
        end
    end

    // Receiver: switches between random stall habits; one long hold-off on request.
    initial begin
        int unsigned habit;
        forever begin
            habit = $urandom_range(0, 3);
            for (int c = 0; c < 64; c++) begin
                @(posedge i_clk);
                if (hold_request) begin
                    i_stall <= 1'b1;
                    repeat (LongHold) @(posedge i_clk);
                    hold_request = 0;
                end
                case (habit)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Directed rows: the first few results follow straight from the reset state.
    directed_row_t directed [] = '{
        '{32'hfff0_0093, 1, known_result(64'd4,  1, 5'd1, '1, 0, 0)},        // addi x1,x0,-1
        '{32'h8000_0137, 1, known_result(64'd8,  1, 5'd2, 64'hffff_ffff_8000_0000, 0, 0)},
        '{32'h0010_3023, 1, known_result(64'd12, 0, 5'd0, '0, 1, 0)},        // sd x1,0(x0)
        '{32'h0000_3183, 1, known_result(64'd16, 1, 5'd3, '1, 0, 0)},        // ld x3,0(x0)
        '{32'h0000_0000, 1, known_result(64'd20, 0, 5'd0, '0, 0, 1)},        // all zero
        '{32'hffff_ffff, 1, known_result(64'd24, 0, 5'd0, '0, 0, 1)},        // all one
        '{InstrEcall,    1, known_result(64'd28, 0, 5'd0, '0, 0, 0)},
        '{InstrEbreak,   1, known_result(64'd32, 0, 5'd0, '0, 0, 0)},
        '{32'h0000_000f, 1, known_result(64'd36, 0, 5'd0, '0, 0, 0)},        // fence
        '{32'h0050_0013, 1, known_result(64'd40, 0, 5'd0, '0, 0, 0)},        // write to x0
        '{32'h0000_2063, 1, known_result(64'd44, 0, 5'd0, '0, 0, 1)},        // branch funct3 2
        '{32'h43f0_d293, 0, '0},   // srai x5,x1,63
        '{32'h4010_0333, 0, '0},   // sub x6,x0,x1
        '{32'h0001_039b, 0, '0},   // addiw x7,x2,0
        '{32'h0000_7183, 0, '0},   // load funct3 7
        '{32'h0010_4023, 0, '0},   // store funct3 4
        '{32'h0010_0423, 0, '0},   // sb x1,8(x0)
        '{32'h0080_4403, 0, '0},   // lbu x8,8(x0)
        '{32'h0080_0483, 0, '0},   // lb x9,8(x0)
        '{32'h0210_1513, 0, '0},   // slli x10,x0,33
        '{32'h0211_5593, 0, '0},   // srli x11,x2,33
        '{32'h0211_0633, 0, '0},   // add with bad funct7
        '{32'h0000_0463, 0, '0},   // beq x0,x0,+8
        '{32'hffdf_f0ef, 0, '0},   // jal x1,-4
        '{32'h0000_8067, 0, '0}    // jalr x0,0(x1)
    };

    initial begin
        logic [63:0]  bases [4];
        exec_result_t r;
        bases = '{64'd0, 64'hffff_ffff_ffff_f800, '1, 64'h0000_0000_0000_0400};
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        for (int i = 0; i < MemSize; i++) arch_mem[i] = '0;
        arch_pc = '0; arch_base = '0;
        mismatches = 0; hold_request = 0; burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (bases[p]) begin
            set_mem_base(bases[p]);
            if (p == 0) begin
                foreach (directed[d]) begin
                    send_request(directed[d].instr, r);
                    if (directed[d].known && r !== directed[d].want) begin
                        $display("MISMATCH at %0t: directed row %0d predicted %h, table %h",
                                 $realtime, d, r, directed[d].want);
                        mismatches++;
                    end
                end
            end
            for (int n = 0; n < RandItems; n++) begin
                if (p == 1 && n == RandItems / 2) hold_request = 1;
                send_request(random_instr(), r);
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
        if (mismatches == 0)
            $display("rv64i_execute_unit_test passed");
        else
            $display("rv64i_execute_unit_test failed");
        $finish;
    end

    // Watchdog: clearing pass plus all requests fit well inside this.
    initial begin
        #20ms;
        $display("rv64i_execute_unit_test failed");
        $finish;
    end
endmodule
`default_nettype wire
